>>> sv/lppm_pkg.sv
package lppm_pkg;

  localparam logic [2:0] MODE_GET    = 3'd0;
  localparam logic [2:0] MODE_INSERT = 3'd1;
  localparam logic [2:0] MODE_SET    = 3'd2;
  localparam logic [2:0] MODE_REMOVE = 3'd3;
  localparam logic [2:0] MODE_ANY    = 3'd4;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_MISS     = 2'd1;
  localparam logic [1:0] ST_REFUSED  = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic load;
    logic rd_start;
    logic rd_next;
    logic rd_shift;
    logic shift_start;
    logic wr_ins;
    logic wr_val;
    logic wr_move;
    logic wr_clear;
    logic cnt_inc;
    logic cnt_dec;
    logic clr_step;
    logic res_load;
    logic [1:0] res_status;
    logic res_use_val;
  } lppm_cmd_t;

  typedef struct packed {
    logic key_zero;
    logic slot_empty;
    logic slot_match;
    logic walk_done;
    logic cnt_zero;
    logic cnt_full;
    logic shift_skip;
    logic clr_done;
    logic [2:0] mode;
  } lppm_sts_t;

endpackage

>>> sv/lppm_datapath.sv
module lppm_datapath
  import lppm_pkg::*;
#(
  parameter int TABLE_SIZE = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  lppm_cmd_t   cmd,
  output lppm_sts_t   sts,
  input  logic [2:0]  in_mode,
  input  logic [63:0] in_key_in,
  input  logic [63:0] in_value_in,
  output logic [63:0] res_value,
  output logic [1:0]  res_status,
  output logic [6:0]  res_total
);
  localparam int AW = $clog2(TABLE_SIZE);
  localparam int CW = $clog2(TABLE_SIZE + 1);
  localparam logic [AW-1:0] HOME_MASK = AW'(TABLE_SIZE - 2);
  localparam logic [CW-1:0] FILL_LIMIT = CW'(TABLE_SIZE - (TABLE_SIZE >> 2));

  logic [63:0] key_mem [TABLE_SIZE];
  logic [63:0] val_mem [TABLE_SIZE];

  logic [2:0]    mode_r;
  logic [63:0]   key_r, val_r;
  logic [AW-1:0] idx_r, idx_nxt, dst_r, wr_addr;
  logic [AW:0]   walk_r;
  logic [CW-1:0] cnt_r;
  logic [63:0]   rk_r, rv_r;
  logic [AW:0]   clr_r;
  logic [63:0]   wk, wv;
  logic          we;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] home_in, home_rd;
  logic [31:0]   h_in, h_rd;
  logic          shift_skip;

  assign h_in = in_key_in[31:0] ^ in_key_in[63:32];
  assign home_in = h_in[AW-1:0] & HOME_MASK;
  assign h_rd = rk_r[31:0] ^ rk_r[63:32];
  assign home_rd = h_rd[AW-1:0] & HOME_MASK;
  assign idx_nxt = idx_r + AW'(1);

  always_comb begin
    rd_addr = idx_nxt;
    if (cmd.rd_start) rd_addr = home_in;
    we = 1'b1;
    wr_addr = idx_r;
    wk = key_r;
    wv = val_r;
    priority if (cmd.clr_step) begin
      wr_addr = clr_r[AW-1:0];
      wk = '0;
      wv = '0;
    end else if (cmd.wr_ins) begin
      wr_addr = idx_r;
    end else if (cmd.wr_val) begin
      wk = rk_r;
    end else if (cmd.wr_move) begin
      wr_addr = dst_r;
      wk = rk_r;
      wv = rv_r;
    end else if (cmd.wr_clear) begin
      wr_addr = dst_r;
      wk = '0;
      wv = '0;
    end else begin
      we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[wr_addr] <= wk;
      val_mem[wr_addr] <= wv;
    end
    if (cmd.rd_start || cmd.rd_next || cmd.rd_shift) begin
      rk_r <= key_mem[rd_addr];
      rv_r <= val_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      clr_r <= '0;
    end else begin
      if (cmd.clr_step) clr_r <= clr_r + (AW+1)'(1);
      if (cmd.cnt_inc) cnt_r <= cnt_r + CW'(1);
      else if (cmd.cnt_dec) cnt_r <= cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      key_r  <= in_key_in;
      val_r  <= in_value_in;
    end
    if (cmd.rd_start) begin
      idx_r  <= home_in;
      walk_r <= '0;
    end else if (cmd.rd_next || cmd.rd_shift) begin
      idx_r  <= idx_nxt;
      walk_r <= cmd.shift_start ? '0 : walk_r + (AW+1)'(1);
    end
    if (cmd.load) dst_r <= '0;
    else if (cmd.wr_move || cmd.shift_start) dst_r <= idx_r;
    if (cmd.res_load) begin
      res_value  <= cmd.res_use_val ? (cmd.wr_val ? val_r : rv_r) : '0;
      res_status <= cmd.res_status;
      res_total  <= 7'(cnt_r + (cmd.cnt_inc ? CW'(1) : CW'(0))
                        - (cmd.cnt_dec ? CW'(1) : CW'(0)));
    end
  end

  // backward shift: entry at idx stays when its home lies cyclically in (dst, idx]
  always_comb begin
    if (home_rd > idx_r)
      shift_skip = (dst_r > idx_r) && (home_rd > dst_r);
    else
      shift_skip = (dst_r > idx_r) || (home_rd > dst_r);
  end

  assign sts.shift_skip = shift_skip;
  assign sts.key_zero   = (key_r == '0);
  assign sts.slot_empty = (rk_r == '0);
  assign sts.slot_match = (rk_r == key_r);
  assign sts.walk_done  = (walk_r == (AW+1)'(TABLE_SIZE - 1));
  assign sts.cnt_zero   = (cnt_r == '0);
  assign sts.cnt_full   = (cnt_r >= FILL_LIMIT);
  assign sts.clr_done   = (clr_r == (AW+1)'(TABLE_SIZE - 1));
  assign sts.mode       = mode_r;
endmodule

>>> sv/lppm_ctrl.sv
module lppm_ctrl
  import lppm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  lppm_sts_t sts,
  output lppm_cmd_t cmd
);
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_SHRD  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       ov_r, ov_nxt;

  assign in_ready  = (state_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    ov_nxt = ov_r && !out_ready;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          cmd.rd_start = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_PROBE;
      S_PROBE: begin
        cmd.res_load = 1'b1;
        state_nxt = S_IDLE;
        ov_nxt = 1'b1;
        unique case (sts.mode)
          MODE_GET, MODE_REMOVE: begin
            if (sts.cnt_zero) cmd.res_status = ST_EMPTY;
            else if (sts.key_zero || sts.slot_empty) cmd.res_status = ST_MISS;
            else if (sts.slot_match) begin
              cmd.res_status = ST_DONE;
              if (sts.mode == MODE_GET) cmd.res_use_val = 1'b1;
              else begin
                cmd.res_load = 1'b0;
                ov_nxt = ov_r && !out_ready;
                cmd.rd_shift = 1'b1;
                cmd.shift_start = 1'b1;
                state_nxt = S_SHRD;
              end
            end else if (sts.walk_done) cmd.res_status = ST_MISS;
            else begin
              cmd.res_load = 1'b0;
              ov_nxt = ov_r && !out_ready;
              cmd.rd_next = 1'b1;
              state_nxt = S_READ;
            end
          end
          MODE_INSERT, MODE_SET: begin
            if (sts.key_zero) cmd.res_status = ST_REFUSED;
            else if (sts.slot_match) begin
              cmd.res_status = ST_DONE;
              cmd.res_use_val = 1'b1;
              if (sts.mode == MODE_SET) cmd.wr_val = 1'b1;
            end else if (sts.slot_empty || sts.walk_done) begin
              if (sts.cnt_full || !sts.slot_empty) cmd.res_status = ST_REFUSED;
              else begin
                cmd.res_status = ST_MISS;
                cmd.wr_ins = 1'b1;
                cmd.cnt_inc = 1'b1;
              end
            end else begin
              cmd.res_load = 1'b0;
              ov_nxt = ov_r && !out_ready;
              cmd.rd_next = 1'b1;
              state_nxt = S_READ;
            end
          end
          MODE_ANY: begin
            if (sts.cnt_zero) cmd.res_status = ST_EMPTY;
            else if (!sts.slot_empty) begin
              cmd.res_status = ST_DONE;
              cmd.res_use_val = 1'b1;
            end else if (sts.walk_done) cmd.res_status = ST_MISS;
            else begin
              cmd.res_load = 1'b0;
              ov_nxt = ov_r && !out_ready;
              cmd.rd_next = 1'b1;
              state_nxt = S_READ;
            end
          end
          default: cmd.res_status = ST_DONE;
        endcase
      end
      S_SHRD: state_nxt = S_SHIFT;
      S_SHIFT: begin
        if (sts.slot_empty || sts.walk_done) begin
          cmd.wr_clear = 1'b1;
          cmd.cnt_dec = 1'b1;
          cmd.res_load = 1'b1;
          cmd.res_status = ST_DONE;
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          if (!sts.shift_skip) cmd.wr_move = 1'b1;
          cmd.rd_shift = 1'b1;
          state_nxt = S_SHRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
    end
  end
endmodule

>>> sv/linear_probe_pointer_map.sv
// out_valid follows accept via the read and probe states; each further slot repeats both states
// remove then closes the gap by backward shift, passing each walked slot through shift-read and shift
// one word in flight at a time; the next word is accepted only after out_ready takes the result
// the table read port sets the pace: each slot read is probed before the next slot is read
// after reset a clearing pass zeroes every slot of the table before in_ready rises
module linear_probe_pointer_map
  import lppm_pkg::*;
#(
  parameter int TABLE_SIZE = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [63:0] in_key_in,
  input  logic [63:0] in_value_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_value_out,
  output logic [1:0]  out_status,
  output logic [6:0]  out_entry_total
);
  lppm_cmd_t cmd;
  lppm_sts_t sts;

  lppm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  lppm_datapath #(.TABLE_SIZE(TABLE_SIZE)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_mode(in_mode), .in_key_in(in_key_in), .in_value_in(in_value_in),
    .res_value(out_value_out), .res_status(out_status), .res_total(out_entry_total)
  );
endmodule

>>> dv/linear_probe_pointer_map_checker.sv
module linear_probe_pointer_map_checker
  import lppm_pkg::*;
#(
  parameter int TABLE_SIZE = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic [63:0] in_key_in,
  input  logic [63:0] in_value_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_value_out,
  input  logic [1:0]  out_status,
  input  logic [6:0]  out_entry_total,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FILL_LIMIT = TABLE_SIZE - (TABLE_SIZE >> 2);

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  status;
    logic [6:0]  total;
  } answer_t;

  logic [63:0] keys [TABLE_SIZE];
  logic [63:0] vals [TABLE_SIZE];
  int          stored;
  answer_t     answers [$];

  function automatic int home_of(logic [63:0] k);
    logic [31:0] h;
    h = k[31:0] ^ k[63:32];
    return int'(h & 32'(TABLE_SIZE - 2));
  endfunction

  // returns 1 on hit with slot, else hole of chain
  function automatic bit find_key(logic [63:0] k, output int slot, output int hole);
    int i;
    i = home_of(k);
    hole = i;
    slot = 0;
    for (int n = 0; n < TABLE_SIZE; n++) begin
      if (keys[i] == 0) begin
        hole = i;
        return 0;
      end
      if (keys[i] == k) begin
        slot = i;
        return 1;
      end
      i = (i + 1) % TABLE_SIZE;
    end
    return 0;
  endfunction

  function automatic void shift_out(int start);
    int dst, i, h;
    dst = start;
    i = start;
    for (int n = 0; n < TABLE_SIZE; n++) begin
      i = (i + 1) % TABLE_SIZE;
      if (keys[i] == 0) break;
      h = home_of(keys[i]);
      if (h > i) begin
        if (dst > i && h > dst) continue;
      end else begin
        if (dst > i) continue;
        if (h > dst) continue;
      end
      keys[dst] = keys[i];
      vals[dst] = vals[i];
      dst = i;
    end
    keys[dst] = '0;
    vals[dst] = '0;
  endfunction

  function automatic answer_t apply_op(logic [2:0] m, logic [63:0] k, logic [63:0] v);
    answer_t a;
    int slot, hole, i;
    a = '0;
    a.status = ST_DONE;
    case (m)
      MODE_GET: begin
        if (stored == 0) a.status = ST_EMPTY;
        else if (k != 0 && find_key(k, slot, hole)) a.value = vals[slot];
        else a.status = ST_MISS;
      end
      MODE_INSERT, MODE_SET: begin
        if (k == 0) a.status = ST_REFUSED;
        else if (find_key(k, slot, hole)) begin
          if (m == MODE_SET) vals[slot] = v;
          a.value = vals[slot];
        end else if (stored >= FILL_LIMIT) a.status = ST_REFUSED;
        else begin
          keys[hole] = k;
          vals[hole] = v;
          stored++;
          a.status = ST_MISS;
        end
      end
      MODE_REMOVE: begin
        if (stored == 0) a.status = ST_EMPTY;
        else if (k != 0 && find_key(k, slot, hole)) begin
          stored--;
          shift_out(slot);
        end else a.status = ST_MISS;
      end
      MODE_ANY: begin
        if (stored == 0) a.status = ST_EMPTY;
        else begin
          i = home_of(k);
          a.status = ST_MISS;
          for (int n = 0; n < TABLE_SIZE; n++) begin
            if (keys[i] != 0) begin
              a.value = vals[i];
              a.status = ST_DONE;
              break;
            end
            i = (i + 1) % TABLE_SIZE;
          end
        end
      end
      default: ;
    endcase
    a.total = 7'(stored);
    return a;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    stored = 0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      keys[i] = '0;
      vals[i] = '0;
    end
  end

  assign pending = answers.size();

  always @(posedge clk) begin
    answer_t w;
    if (rst_n) begin
      if (in_valid && in_ready)
        answers.push_back(apply_op(in_mode, in_key_in, in_value_in));
      if (out_valid && out_ready) begin
        if (answers.size() == 0) begin
          $display("unexpected word: value %h status %0d", out_value_out, out_status);
          fail_count++;
        end else begin
          w = answers.pop_front();
          if (out_value_out !== w.value) report("value", out_value_out, w.value);
          if (out_status !== w.status) report("status", 64'(out_status), 64'(w.status));
          if (out_entry_total !== w.total)
            report("entry_total", 64'(out_entry_total), 64'(w.total));
        end
      end
    end
  end
endmodule

>>> dv/linear_probe_pointer_map_tb.sv
module linear_probe_pointer_map_tb;
  import lppm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_SIZE = 64;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [2:0]  in_mode = MODE_GET;
  logic [63:0] in_key_in = '0;
  logic [63:0] in_value_in = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [63:0] out_value_out;
  logic [1:0]  out_status;
  logic [6:0]  out_entry_total;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  bit          hold_off = 0;
  logic [63:0] pool [16];

  always #5 clk = ~clk;

  linear_probe_pointer_map #(.TABLE_SIZE(TABLE_SIZE)) dut (.*);

  linear_probe_pointer_map_checker #(.TABLE_SIZE(TABLE_SIZE)) checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else if (cycles % 400 < 120) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  task automatic send(logic [2:0] m, logic [63:0] k, logic [63:0] v);
    in_valid <= 1'b1;
    in_mode <= m;
    in_key_in <= k;
    in_value_in <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // keys from a pool, keys that collide on home slots 0 and 2, small keys or random keys
  function automatic logic [63:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return pool[$urandom_range(0, 15)];
    if (r < 8) return {32'($urandom_range(0, 3)), 32'($urandom_range(0, 7) * TABLE_SIZE
                       + $urandom_range(0, 3))} | 64'd1;
    if (r == 8) return 64'($urandom_range(0, 3));
    return rand64();
  endfunction

  initial begin
    int items, burst;
    logic [2:0] m;
    for (int i = 0; i < 16; i++) pool[i] = rand64() | 64'd1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(MODE_GET, 64'd5, '0);
    send(MODE_REMOVE, 64'd5, '0);
    send(MODE_ANY, '1, '0);
    send(MODE_INSERT, '0, 64'd9);
    send(MODE_SET, '0, 64'd9);
    send(MODE_INSERT, '1, '1);
    send(MODE_INSERT, 64'h1_0000_0001, 64'h11);
    send(MODE_INSERT, 64'h3, 64'h22);
    send(MODE_INSERT, 64'h2_0000_0003, 64'h33);
    send(MODE_INSERT, 64'h3, 64'h44);
    send(MODE_SET, 64'h3, 64'h55);
    send(MODE_GET, 64'h3, '0);
    send(MODE_GET, '0, '0);
    send(MODE_REMOVE, '0, '0);
    send(MODE_GET, 64'h7777, '0);
    send(MODE_ANY, 64'h3E, '0);
    send(MODE_REMOVE, 64'h1_0000_0001, '0);
    send(MODE_GET, 64'h2_0000_0003, '0);
    send(3'd5, 64'h3, '0);
    send(3'd7, '1, '1);
    send(MODE_SET, 64'hFFFF_FFFF_0000_003F, '1);
    send(MODE_REMOVE, 64'h1234, '0);
    drain();

    // fill to refusal, then empty again
    for (int i = 1; i <= 52; i++) send(MODE_INSERT, 64'(i * 7), rand64());
    send(MODE_SET, 64'd7, 64'hABCD);
    send(MODE_ANY, rand64(), '0);
    drain();
    for (int i = 1; i <= 52; i++) send(MODE_REMOVE, 64'(i * 7), '0);
    drain();

    // long receiver hold-off while the sender keeps offering
    hold_off = 1;
    fork
      repeat (300) @(posedge clk);
      for (int i = 0; i < 30; i++) send(MODE_SET, pick_key(), rand64());
    join_any
    hold_off = 0;
    wait fork;
    drain();

    items = 0;
    while (items < 390) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst; b++) begin
        m = ($urandom_range(0, 30) == 0) ? 3'($urandom_range(5, 7))
                                         : 3'($urandom_range(0, 4));
        send(m, pick_key(), rand64());
        items++;
      end
      if ($urandom_range(0, 40) == 0) drain();
      else idle_gap($urandom_range(0, 6));
    end
    drain();
    repeat (TABLE_SIZE * 6) @(posedge clk);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
